// File: design/alid_pkg.sv
package alid_pkg;

	typedef enum logic [2:0] {
		OP_CLEAR  = 3'd0,
		OP_APPEND = 3'd1,
		OP_INSERT = 3'd2,
		OP_DELETE = 3'd3,
		OP_SEARCH = 3'd4,
		OP_READ   = 3'd5
	} op_t;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	// Per-cycle command shared by every cell of the row
	typedef struct packed {
		logic wr;      // apply the list edit given by op
		logic load;    // capture match flag and entry into the scan chain
		logic shift;   // advance the scan chain by one chunk
		logic search;  // match on key (else match on position)
	} cell_ctl_t;

	localparam int IN_W  = 48;
	localparam int OUT_W = 48;

endpackage

// File: design/array_list_insert_delete_search_top.sv
// Ordered list of up to DEPTH signed values held in a row of cells, one entry per cell.
// Clear, append, insert, delete and every rejected request are completed in their accept cycle: all cells
// shift or write at once. Search and read copy the row into a scan chain in the accept
// cycle, then check eight cells per cycle (all cells if DEPTH is below eight) and stop at the
// chunk that holds the hit or at the end of the row. The next request is taken once the controller
// is idle and the result register is empty or being emptied in the same cycle. Each request gives
// one result with status, search outcome, read data and the count after the request.
module array_list_insert_delete_search_top #(
	parameter int DEPTH      = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	// op[2:0], position[9:3], value[41:10], zero[47:42]
	input  logic [alid_pkg::IN_W-1:0]  s_axis_tdata,
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	// status[0], found[1], found_index[7:2], read_data[39:8], count[46:40], zero[47]
	output logic [alid_pkg::OUT_W-1:0] m_axis_tdata
);
	import alid_pkg::*;

	localparam int CW    = $clog2(DEPTH + 1);
	localparam int PW    = (CW > 7) ? CW : 7;
	localparam int CHUNK = (DEPTH < 8) ? DEPTH : 8;
	localparam int CIW   = $clog2(CHUNK);
	localparam int BW    = $clog2(DEPTH + CHUNK + 1);

	op_t                    in_op;
	logic [6:0]             in_pos;
	logic signed [31:0]     in_val;
	logic [DATA_WIDTH-1:0]  val_dw;
	logic [PW-1:0]          pos_w;
	logic [PW-1:0]          cnt_w;
	logic [CW-1:0]          pos_c;

	state_t                 state_q, state_d;
	logic [CW-1:0]          count_q, count_d;
	logic [BW-1:0]          base_q, base_d;
	logic                   search_q;

	logic                   out_free;
	logic                   accept;
	logic                   full;
	logic                   edit_ok;
	logic                   start_scan;
	logic                   rej;
	logic [CW-1:0]          cnt_next;
	logic                   finish;

	logic                   out_load;
	logic                   out_status, out_found;
	logic [5:0]             out_fidx;
	logic [31:0]            out_rdata;

	logic                   m_valid_q;
	logic                   status_q, found_q;
	logic [5:0]             fidx_q;
	logic [31:0]            rdata_q;
	logic [6:0]             count_out_q;

	cell_ctl_t              ctl;
	logic [DATA_WIDTH-1:0]  entry     [DEPTH];
	logic                   scan_hit  [DEPTH];
	logic [DATA_WIDTH-1:0]  scan_data [DEPTH];
	logic [CHUNK-1:0]       chunk_hit;
	logic [DATA_WIDTH-1:0]  chunk_data [CHUNK];
	logic                   any_hit;
	logic [CIW-1:0]         pick_idx;
	logic [DATA_WIDTH-1:0]  pick_data;

	assign in_op  = op_t'(s_axis_tdata[2:0]);
	assign in_pos = s_axis_tdata[9:3];
	assign in_val = s_axis_tdata[41:10];
	assign val_dw = DATA_WIDTH'(in_val);
	assign pos_w  = PW'(in_pos);
	assign cnt_w  = PW'(count_q);
	assign pos_c  = CW'(in_pos);

	assign out_free      = !m_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE) && out_free;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign full          = (count_q == CW'(DEPTH));
	assign finish        = any_hit || ((base_q + BW'(CHUNK)) >= BW'(DEPTH));

	// Request decode: decide edit, scan or immediate answer
	always_comb begin
		edit_ok    = 1'b0;
		start_scan = 1'b0;
		rej        = 1'b0;
		cnt_next   = count_q;
		unique case (in_op)
			OP_CLEAR: begin
				cnt_next = '0;
			end
			OP_APPEND: begin
				if (full) begin
					rej = 1'b1;
				end else begin
					edit_ok  = 1'b1;
					cnt_next = CW'(count_q + 1'b1);
				end
			end
			OP_INSERT: begin
				if (full || (pos_w > cnt_w)) begin
					rej = 1'b1;
				end else begin
					edit_ok  = 1'b1;
					cnt_next = CW'(count_q + 1'b1);
				end
			end
			OP_DELETE: begin
				if (pos_w >= cnt_w) begin
					rej = 1'b1;
				end else begin
					edit_ok  = 1'b1;
					cnt_next = CW'(count_q - 1'b1);
				end
			end
			OP_SEARCH: begin
				start_scan = 1'b1;
			end
			OP_READ: begin
				if (pos_w >= cnt_w) rej = 1'b1;
				else start_scan = 1'b1;
			end
			default: begin
				rej = 1'b1;
			end
		endcase
	end

	// Controller: next state, cell commands and result register loads
	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		base_d     = base_q;
		ctl        = '0;
		out_load   = 1'b0;
		out_status = 1'b0;
		out_found  = 1'b0;
		out_fidx   = '0;
		out_rdata  = '0;
		unique case (state_q)
			ST_IDLE: begin
				ctl.search = (in_op == OP_SEARCH);
				if (accept) begin
					if (start_scan) begin
						ctl.load = 1'b1;
						base_d   = '0;
						state_d  = ST_SCAN;
					end else begin
						ctl.wr     = edit_ok;
						count_d    = cnt_next;
						out_load   = 1'b1;
						out_status = rej;
					end
				end
			end
			ST_SCAN: begin
				if (!finish) begin
					ctl.shift = 1'b1;
					base_d    = base_q + BW'(CHUNK);
				end else if (out_free) begin
					out_load  = 1'b1;
					out_found = search_q && any_hit;
					if (search_q && any_hit) out_fidx = 6'(base_q + BW'(pick_idx));
					if (!search_q && any_hit) out_rdata = 32'(pick_data);
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			base_q    <= '0;
			search_q  <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			base_q  <= base_d;
			if (ctl.load) search_q <= ctl.search;
			if (out_load) m_valid_q <= 1'b1;
			else if (m_axis_tready) m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q    <= out_status;
			found_q     <= out_found;
			fidx_q      <= out_fidx;
			rdata_q     <= out_rdata;
			count_out_q <= 7'(count_d);
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {1'b0, count_out_q, rdata_q, fidx_q, found_q, status_q};

	// Row of cells
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic [DATA_WIDTH-1:0] prev_e, next_e, sdata_in;
		logic                  shit_in;

		if (g == 0) begin : g_first
			assign prev_e = '0;
		end else begin : g_mid
			assign prev_e = entry[g-1];
		end
		if (g == DEPTH - 1) begin : g_last
			assign next_e = '0;
		end else begin : g_inner
			assign next_e = entry[g+1];
		end
		if (g + CHUNK < DEPTH) begin : g_feed
			assign shit_in  = scan_hit[g+CHUNK];
			assign sdata_in = scan_data[g+CHUNK];
		end else begin : g_tail
			assign shit_in  = 1'b0;
			assign sdata_in = '0;
		end

		alid_cell #(
			.DW(DATA_WIDTH),
			.CW(CW)
		) u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.op          (in_op),
			.idx         (CW'(g)),
			.pos         (pos_c),
			.cnt         (count_q),
			.value       (val_dw),
			.prev_entry  (prev_e),
			.next_entry  (next_e),
			.scan_hit_in (shit_in),
			.scan_data_in(sdata_in),
			.entry       (entry[g]),
			.scan_hit    (scan_hit[g]),
			.scan_data   (scan_data[g])
		);
	end

	for (genvar k = 0; k < CHUNK; k++) begin : g_chunk
		assign chunk_hit[k]  = scan_hit[k];
		assign chunk_data[k] = scan_data[k];
	end

	alid_pick #(
		.CHUNK(CHUNK),
		.DW   (DATA_WIDTH)
	) u_pick (
		.hit      (chunk_hit),
		.data     (chunk_data),
		.any_hit  (any_hit),
		.pick_idx (pick_idx),
		.pick_data(pick_data)
	);

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_base_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (base_q < BW'(DEPTH)))
		else $error("scan base past the row");

	a_read_hits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && !search_q && finish) |-> any_hit)
		else $error("read scan ended without reaching its position");

	a_quick_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !start_scan) |=> m_axis_tvalid)
		else $error("single-cycle request gave no result");

endmodule

// File: design/alid_cell.sv
module alid_cell #(
	parameter int DW = 32,
	parameter int CW = 7
) (
	input  logic              clk,
	input  alid_pkg::cell_ctl_t ctl,
	input  alid_pkg::op_t     op,
	input  logic [CW-1:0]     idx,
	input  logic [CW-1:0]     pos,
	input  logic [CW-1:0]     cnt,
	input  logic [DW-1:0]     value,
	input  logic [DW-1:0]     prev_entry,
	input  logic [DW-1:0]     next_entry,
	input  logic              scan_hit_in,
	input  logic [DW-1:0]     scan_data_in,
	output logic [DW-1:0]     entry,
	output logic              scan_hit,
	output logic [DW-1:0]     scan_data
);
	import alid_pkg::*;

	logic [DW-1:0] entry_q;
	logic          hit_q;
	logic [DW-1:0] sdata_q;

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			case (op)
				OP_APPEND: begin
					if (idx == cnt) entry_q <= value;
				end
				OP_INSERT: begin
					if (idx == pos) entry_q <= value;
					else if (idx > pos) entry_q <= prev_entry;
				end
				OP_DELETE: begin
					if (idx >= pos) entry_q <= next_entry;
				end
				default: begin
					entry_q <= entry_q;
				end
			endcase
		end
	end

	// Scan chain: load a snapshot, then move it toward cell 0 one chunk a cycle while shift is set
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			hit_q   <= ctl.search ? ((idx < cnt) && (entry_q == value)) : (idx == pos);
			sdata_q <= entry_q;
		end else if (ctl.shift) begin
			hit_q   <= scan_hit_in;
			sdata_q <= scan_data_in;
		end
	end

	assign entry     = entry_q;
	assign scan_hit  = hit_q;
	assign scan_data = sdata_q;

endmodule

// File: design/alid_pick.sv
module alid_pick #(
	parameter int CHUNK = 8,
	parameter int DW    = 32
) (
	input  logic [CHUNK-1:0]         hit,
	input  logic [DW-1:0]            data [CHUNK],
	output logic                     any_hit,
	output logic [$clog2(CHUNK)-1:0] pick_idx,
	output logic [DW-1:0]            pick_data
);
	localparam int CIW = $clog2(CHUNK);

	always_comb begin
		any_hit   = 1'b0;
		pick_idx  = '0;
		pick_data = data[0];
		// walk down so the lowest set flag wins
		for (int j = CHUNK - 1; j >= 0; j--) begin
			if (hit[j]) begin
				any_hit   = 1'b1;
				pick_idx  = CIW'(j);
				pick_data = data[j];
			end
		end
	end

endmodule

// File: dv/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import alid_pkg::*;

	localparam int LIST_DEPTH   = 64;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 20;
	localparam int MAX_REPORTS  = 10;

	// op codes the block does not define; both must be rejected
	localparam logic [2:0] OP_SPARE6 = 3'd6;
	localparam logic [2:0] OP_SPARE7 = 3'd7;

	typedef struct packed {
		logic        status;
		logic        found;
		logic [5:0]  found_index;
		logic [31:0] read_data;
		logic [6:0]  count;
	} list_resp_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [IN_W-1:0]  s_axis_tdata = '0;
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;

	// shadow copy of the list, updated in request order
	logic [31:0] list_mem [LIST_DEPTH];
	int          list_len = 0;

	list_resp_t resp_q [$];
	int         fail_count = 0;
	int         cycle_count = 0;
	bit         steady = 1'b0;

	array_list_insert_delete_search_top #(
		.DEPTH      (LIST_DEPTH),
		.DATA_WIDTH (32)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL array_list_insert_delete_search_top");
			$finish;
		end
	end

	// Apply one request to the shadow list and return the response it must produce.
	function automatic list_resp_t apply_list_op(logic [2:0] op, logic [6:0] pos,
			logic [31:0] val);
		list_resp_t r;
		int i;
		r = '0;
		case (op)
			OP_CLEAR: list_len = 0;
			OP_APPEND: begin
				if (list_len >= LIST_DEPTH) begin
					r.status = 1'b1;
				end else begin
					list_mem[list_len] = val;
					list_len++;
				end
			end
			OP_INSERT: begin
				if (list_len >= LIST_DEPTH || pos > list_len) begin
					r.status = 1'b1;
				end else begin
					for (i = list_len; i > pos; i--)
						list_mem[i] = list_mem[i-1];
					list_mem[pos] = val;
					list_len++;
				end
			end
			OP_DELETE: begin
				if (pos >= list_len) begin
					r.status = 1'b1;
				end else begin
					for (i = pos; i + 1 < list_len; i++)
						list_mem[i] = list_mem[i+1];
					list_len--;
				end
			end
			OP_SEARCH: begin
				// lowest matching index wins
				for (i = 0; i < list_len; i++) begin
					if (!r.found && list_mem[i] == val) begin
						r.found = 1'b1;
						r.found_index = i[5:0];
					end
				end
			end
			OP_READ: begin
				if (pos >= list_len)
					r.status = 1'b1;
				else
					r.read_data = list_mem[pos];
			end
			default: r.status = 1'b1;
		endcase
		r.count = list_len[6:0];
		return r;
	endfunction

	task automatic report_mismatch(string field, longint unsigned want_v,
			longint unsigned got_v);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("mismatch in %s at %0t: expected 0x%0h, got 0x%0h", field, $realtime,
				want_v, got_v);
	endtask

	// Response checker
	always @(posedge clk) begin
		list_resp_t got;
		list_resp_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.status      = m_axis_tdata[0];
			got.found       = m_axis_tdata[1];
			got.found_index = m_axis_tdata[7:2];
			got.read_data   = m_axis_tdata[39:8];
			got.count       = m_axis_tdata[46:40];
			if (resp_q.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("unexpected response at %0t: 0x%0h", $realtime, m_axis_tdata);
			end else begin
				want = resp_q.pop_front();
				if (got.status !== want.status)
					report_mismatch("status", want.status, got.status);
				if (got.found !== want.found)
					report_mismatch("found", want.found, got.found);
				if (got.found_index !== want.found_index)
					report_mismatch("found_index", want.found_index, got.found_index);
				if (got.read_data !== want.read_data)
					report_mismatch("read_data", want.read_data, got.read_data);
				if (got.count !== want.count)
					report_mismatch("count", want.count, got.count);
			end
		end
	end

	// Response side backpressure
	always @(negedge clk)
		m_axis_tready <= steady || ($urandom_range(99) >= 22);

	task automatic send_request(input logic [2:0] op, input logic [6:0] pos,
			input logic [31:0] val);
		@(negedge clk);
		while (!steady && $urandom_range(99) < 22) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {6'd0, val, pos, op};
		do @(posedge clk); while (!s_axis_tready);
		resp_q.push_back(apply_list_op(op, pos, val));
	endtask

	// Hold off new requests until every response is back.
	task automatic wait_all_results();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (resp_q.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2, 3: return 32'($signed($urandom_range(4)) - 2);
			default: return $urandom;
		endcase
	endfunction

	// Search key: mostly a value already in the list
	function automatic logic [31:0] pick_key();
		if (list_len > 0 && $urandom_range(9) < 6)
			return list_mem[$urandom_range(list_len - 1)];
		return pick_value();
	endfunction

	// Position: mostly in range for the op, sometimes anywhere in 0..64
	function automatic logic [6:0] pick_pos(logic [2:0] op);
		if ($urandom_range(9) < 2)
			return 7'($urandom_range(LIST_DEPTH));
		if (op == OP_INSERT)
			return 7'($urandom_range(list_len));
		if (list_len == 0)
			return 7'd0;
		return 7'($urandom_range(list_len - 1));
	endfunction

	task automatic test_empty_list();
		send_request(OP_READ, 7'd0, 32'd0);
		send_request(OP_DELETE, 7'd0, 32'd0);
		send_request(OP_SEARCH, 7'd0, 32'd0);
		send_request(OP_INSERT, 7'd1, 32'd5);
		send_request(OP_INSERT, 7'd64, 32'd5);
		send_request(OP_SPARE6, 7'd0, 32'hFFFF_FFFF);
		send_request(OP_SPARE7, 7'd64, 32'h1234_5678);
	endtask

	task automatic test_edit_extremes();
		send_request(OP_APPEND, 7'd0, 32'h8000_0000);
		send_request(OP_APPEND, 7'd0, 32'h7FFF_FFFF);
		send_request(OP_INSERT, 7'd0, 32'd0);
		send_request(OP_INSERT, 7'd3, 32'hFFFF_FFFF);
		send_request(OP_INSERT, 7'd5, 32'd9);
		send_request(OP_APPEND, 7'd0, 32'h7FFF_FFFF);
		send_request(OP_SEARCH, 7'd0, 32'h7FFF_FFFF);
		send_request(OP_SEARCH, 7'd0, 32'hFFFF_FFFF);
		send_request(OP_SEARCH, 7'd0, 32'd12345);
		send_request(OP_READ, 7'd0, 32'd0);
		send_request(OP_READ, 7'd4, 32'd0);
		send_request(OP_READ, 7'd5, 32'd0);
		send_request(OP_DELETE, 7'd0, 32'd0);
		send_request(OP_DELETE, 7'd3, 32'd0);
		send_request(OP_DELETE, 7'd3, 32'd0);
		send_request(OP_SEARCH, 7'd0, 32'h8000_0000);
		send_request(OP_CLEAR, 7'd0, 32'd0);
		send_request(OP_READ, 7'd0, 32'd0);
		// stale entries past the count must not match
		send_request(OP_SEARCH, 7'd0, 32'h8000_0000);
	endtask

	task automatic test_fill_and_drain();
		while (list_len < LIST_DEPTH) begin
			if (list_len > 0 && $urandom_range(3) == 0)
				send_request(OP_INSERT, 7'($urandom_range(list_len)), pick_value());
			else
				send_request(OP_APPEND, 7'($urandom_range(LIST_DEPTH)), pick_value());
		end
		send_request(OP_APPEND, 7'd0, pick_value());
		send_request(OP_INSERT, 7'd64, pick_value());
		send_request(OP_INSERT, 7'd0, pick_value());
		send_request(OP_SEARCH, 7'd0, list_mem[LIST_DEPTH-1]);
		send_request(OP_READ, 7'd63, 32'd0);
		send_request(OP_READ, 7'd64, 32'd0);
		send_request(OP_DELETE, 7'd64, 32'd0);
		wait_all_results();
		while (list_len > 0) begin
			case ($urandom_range(3))
				0: send_request(OP_SEARCH, 7'd0, pick_key());
				1: send_request(OP_READ, pick_pos(OP_READ), 32'd0);
				default: send_request(OP_DELETE, pick_pos(OP_DELETE), 32'd0);
			endcase
		end
	endtask

	task automatic test_random_mix(input int n_items);
		int k;
		int r;
		logic [2:0] op;
		for (k = 0; k < n_items; k++) begin
			r = $urandom_range(99);
			if (r < 20)
				op = OP_APPEND;
			else if (r < 40)
				op = OP_INSERT;
			else if (r < 60)
				op = OP_DELETE;
			else if (r < 77)
				op = OP_SEARCH;
			else if (r < 93)
				op = OP_READ;
			else if (r < 95)
				op = OP_CLEAR;
			else
				op = $urandom_range(1) ? OP_SPARE6 : OP_SPARE7;
			send_request(op, pick_pos(op), (op == OP_SEARCH) ? pick_key() : pick_value());
		end
	endtask

	task automatic test_steady_stream();
		steady = 1'b1;
		test_random_mix(100);
		steady = 1'b0;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_empty_list();
		test_edit_extremes();
		test_fill_and_drain();
		test_random_mix(510);
		test_steady_stream();
		wait_all_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && resp_q.size() == 0)
			$display("PASS array_list_insert_delete_search_top");
		else
			$display("FAIL array_list_insert_delete_search_top");
		$finish;
	end

endmodule
